@@ hdl/arena_block_allocator_assert.svh @@
// Assertion macros used by the checker file.
`ifndef ARENA_BLOCK_ALLOCATOR_ASSERT_SVH
`define ARENA_BLOCK_ALLOCATOR_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define AB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define AB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ab_pkg.sv @@
package ab_pkg;

  // Arena geometry
  localparam int unsigned BUCKET_BYTES = 4096;
  localparam int unsigned BUCKET_COUNT = 64;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAX_BLOCKS   = 256;

  // Field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned ADDR_W = 18;
  localparam int unsigned STAT_W = 3;

  // Derived widths
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned BKT_W  = $clog2(BUCKET_COUNT + 1);
  localparam int unsigned OFF_W  = $clog2(BUCKET_BYTES);
  localparam int unsigned NEED_W = $clog2(HEADER_BYTES + (1 << SIZE_W) + 8);
  localparam int unsigned SUM_W  = $clog2(BUCKET_BYTES + HEADER_BYTES + (1 << SIZE_W) + 8);
  localparam int unsigned PROD_W = BKT_W + $clog2(BUCKET_BYTES + 1) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_RESIZE = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // One block table entry
  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  // Outcome of a bump placement
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] offset;
    logic [BKT_W-1:0]  bucket;
    logic [OFF_W-1:0]  bump;
  } bump_t;

  // Data address sits right after the header, wrapping in the address space
  function automatic logic [ADDR_W-1:0] data_addr(input logic [ADDR_W-1:0] off);
    return off + ADDR_W'(HEADER_BYTES);
  endfunction

endpackage

@@ hdl/ab_ram.sv @@
module ab_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/ab_bump.sv @@
module ab_bump (
  input  logic [ab_pkg::SIZE_W-1:0] size_i,
  input  logic [ab_pkg::CNT_W-1:0]  count_i,
  input  logic [ab_pkg::BKT_W-1:0]  bucket_i,
  input  logic [ab_pkg::OFF_W-1:0]  bump_i,
  output ab_pkg::bump_t             bump_o
);

  logic [ab_pkg::NEED_W-1:0] need_sum;
  logic [ab_pkg::NEED_W-1:0] need;
  logic                      overrun;
  logic [ab_pkg::BKT_W:0]    bkt_inc;
  logic [ab_pkg::BKT_W-1:0]  bkt;
  logic [ab_pkg::OFF_W-1:0]  off;
  logic [ab_pkg::PROD_W-1:0] base;
  logic [ab_pkg::SUM_W-1:0]  off_next;
  logic                      wrap;

  // Header plus data, rounded up to 8 bytes
  assign need_sum = ab_pkg::NEED_W'(ab_pkg::HEADER_BYTES) + ab_pkg::NEED_W'(size_i)
                  + ab_pkg::NEED_W'(7);
  assign need     = {need_sum[ab_pkg::NEED_W-1:3], 3'b000};

  // Block that would cross the bucket end starts the next bucket
  assign overrun = (ab_pkg::SUM_W'(bump_i) + ab_pkg::SUM_W'(need))
                 > ab_pkg::SUM_W'(ab_pkg::BUCKET_BYTES);
  assign bkt_inc = {1'b0, bucket_i} + (ab_pkg::BKT_W + 1)'(1);
  assign bkt     = overrun ? bkt_inc[ab_pkg::BKT_W-1:0] : bucket_i;
  assign off     = overrun ? '0 : bump_i;

  // Header address of the new block
  assign base = ab_pkg::PROD_W'(bkt) * ab_pkg::PROD_W'(ab_pkg::BUCKET_BYTES)
              + ab_pkg::PROD_W'(off);

  // Advance; a nearly full bucket is left behind
  assign off_next = ab_pkg::SUM_W'(off) + ab_pkg::SUM_W'(need);
  assign wrap     = off_next >= ab_pkg::SUM_W'(ab_pkg::BUCKET_BYTES - 1);

  always_comb begin
    bump_o.offset = ab_pkg::ADDR_W'(base);
    bump_o.bucket = wrap ? bkt + ab_pkg::BKT_W'(1) : bkt;
    bump_o.bump   = wrap ? '0 : off_next[ab_pkg::OFF_W-1:0];
    if (ab_pkg::SUM_W'(need) > ab_pkg::SUM_W'(ab_pkg::BUCKET_BYTES)) begin
      bump_o.status = ab_pkg::ST_FULL;
    end else if (count_i >= ab_pkg::CNT_W'(ab_pkg::MAX_BLOCKS)) begin
      bump_o.status = ab_pkg::ST_FULL;
    end else if (bucket_i >= ab_pkg::BKT_W'(ab_pkg::BUCKET_COUNT)) begin
      bump_o.status = ab_pkg::ST_EXHAUSTED;
    end else if (overrun && (bkt_inc >= (ab_pkg::BKT_W + 1)'(ab_pkg::BUCKET_COUNT))) begin
      bump_o.status = ab_pkg::ST_EXHAUSTED;
    end else begin
      bump_o.status = ab_pkg::ST_OK;
    end
  end

endmodule

@@ hdl/arena_block_allocator.sv @@
// Allocate and free make one scan of the block table from transfer to result valid;
//   a moving resize scans twice.
// Throughput: one request at a time, set by the block table RAM, read one entry a cycle.
//   A new request is taken while the previous result still waits on the output register.
// Reset: counters, bucket and bump offset clear at once; table contents stay undefined.
module arena_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ab_pkg::KIND_W-1:0] kind_i,
  input  logic [ab_pkg::SIZE_W-1:0] size_bytes_i,
  input  logic [ab_pkg::ADDR_W-1:0] address_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ab_pkg::ADDR_W-1:0] result_address_o,
  output logic [ab_pkg::ADDR_W-1:0] copy_from_o,
  output logic                      copy_needed_o,
  output logic [ab_pkg::STAT_W-1:0] status_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_ACT      = 5'b00100,
    S_FREE_OLD = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  typedef enum logic {
    MODE_FIND = 1'b0,
    MODE_FIT  = 1'b1
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   moving_q, moving_d;

  logic [ab_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [ab_pkg::SIZE_W-1:0] size_q, size_d;
  logic [ab_pkg::ADDR_W-1:0] addr_q, addr_d;

  // Arena state
  logic [ab_pkg::CNT_W-1:0] count_q, count_d;
  logic [ab_pkg::BKT_W-1:0] bucket_q, bucket_d;
  logic [ab_pkg::OFF_W-1:0] bump_q, bump_d;

  // Scan pipeline
  logic [ab_pkg::CNT_W-1:0] issue_idx_q, issue_idx_d;
  logic                     pend_q, pend_d;
  logic [ab_pkg::IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic                     hit_q, hit_d;
  logic [ab_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  ab_pkg::entry_t           hit_ent_q, hit_ent_d;
  logic [ab_pkg::IDX_W-1:0] old_idx_q, old_idx_d;
  ab_pkg::entry_t           old_ent_q, old_ent_d;
  logic                     scan_match;

  // Working result
  logic [ab_pkg::ADDR_W-1:0] res_q, res_d;
  logic [ab_pkg::ADDR_W-1:0] from_q, from_d;
  logic                      copy_q, copy_d;
  ab_pkg::status_e           status_q, status_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic [ab_pkg::ADDR_W-1:0] out_res_q, out_res_d;
  logic [ab_pkg::ADDR_W-1:0] out_from_q, out_from_d;
  logic                      out_copy_q, out_copy_d;
  ab_pkg::status_e           out_status_q, out_status_d;

  // RAM ports
  logic                     rd_en;
  logic [ab_pkg::IDX_W-1:0] rd_addr;
  ab_pkg::entry_t           rd_data;
  logic                     wr_en;
  logic [ab_pkg::IDX_W-1:0] wr_addr;
  ab_pkg::entry_t           wr_data;

  ab_pkg::bump_t bump;

  ab_ram #(
    .WIDTH ($bits(ab_pkg::entry_t)),
    .DEPTH (ab_pkg::MAX_BLOCKS)
  ) u_ab_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ab_bump u_ab_bump (
    .size_i   (size_q),
    .count_i  (count_q),
    .bucket_i (bucket_q),
    .bump_i   (bump_q),
    .bump_o   (bump)
  );

  // Compare the entry that just came back from the RAM
  always_comb begin
    if (mode_q == MODE_FIND) begin
      scan_match = pend_q && (ab_pkg::data_addr(rd_data.offset) == addr_q);
    end else begin
      scan_match = pend_q && rd_data.free && (rd_data.size == size_q);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    moving_d     = moving_q;
    kind_d       = kind_q;
    size_d       = size_q;
    addr_d       = addr_q;
    count_d      = count_q;
    bucket_d     = bucket_q;
    bump_d       = bump_q;
    issue_idx_d  = issue_idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_ent_d    = hit_ent_q;
    old_idx_d    = old_idx_q;
    old_ent_d    = old_ent_q;
    res_d        = res_q;
    from_d       = from_q;
    copy_d       = copy_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    out_from_d   = out_from_q;
    out_copy_d   = out_copy_q;
    out_status_d = out_status_q;
    rd_en        = 1'b0;
    rd_addr      = issue_idx_q[ab_pkg::IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = hit_idx_q;
    wr_data      = hit_ent_q;

    // Result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d      = kind_i;
          size_d      = size_bytes_i;
          addr_d      = address_i;
          res_d       = '0;
          from_d      = '0;
          copy_d      = 1'b0;
          status_d    = ab_pkg::ST_NULL;
          moving_d    = 1'b0;
          issue_idx_d = '0;
          pend_d      = 1'b0;
          state_d     = S_DONE;
          case (kind_i)
            ab_pkg::KIND_ALLOC: begin
              if (size_bytes_i != '0) begin
                mode_d  = MODE_FIT;
                state_d = S_SCAN;
              end
            end
            ab_pkg::KIND_FREE, ab_pkg::KIND_RESIZE: begin
              if (address_i != '0) begin
                mode_d  = MODE_FIND;
                state_d = S_SCAN;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // One read issued per cycle, compared in the cycle after
      S_SCAN: begin
        if (issue_idx_q < count_q) begin
          rd_en       = 1'b1;
          issue_idx_d = issue_idx_q + ab_pkg::CNT_W'(1);
          pend_d      = 1'b1;
          pend_idx_d  = issue_idx_q[ab_pkg::IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (scan_match) begin
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
          hit_ent_d = rd_data;
          pend_d    = 1'b0;
          state_d   = S_ACT;
        end else if (!pend_q && (issue_idx_q >= count_q)) begin
          hit_d   = 1'b0;
          state_d = S_ACT;
        end
      end

      S_ACT: begin
        state_d = S_DONE;
        if (mode_q == MODE_FIND) begin
          if (!hit_q) begin
            status_d = ab_pkg::ST_UNKNOWN;
          end else begin
            old_idx_d = hit_idx_q;
            old_ent_d = hit_ent_q;
            if (kind_q == ab_pkg::KIND_FREE) begin
              wr_en        = 1'b1;
              wr_data.free = 1'b1;
              status_d     = ab_pkg::ST_OK;
            end else if (size_q == '0) begin
              // Resize to nothing frees the block
              wr_en        = 1'b1;
              wr_data.free = 1'b1;
              status_d     = ab_pkg::ST_NULL;
            end else if ((ab_pkg::CNT_W'(hit_idx_q) + ab_pkg::CNT_W'(1)) == count_q) begin
              // Newest block is resized in place
              wr_en        = 1'b1;
              wr_data.size = size_q;
              res_d        = addr_q;
              status_d     = ab_pkg::ST_OK;
            end else begin
              mode_d      = MODE_FIT;
              moving_d    = 1'b1;
              issue_idx_d = '0;
              pend_d      = 1'b0;
              state_d     = S_SCAN;
            end
          end
        end else if (hit_q) begin
          // Exact-fit reuse of a freed block
          wr_en        = 1'b1;
          wr_data.free = 1'b0;
          res_d        = ab_pkg::data_addr(hit_ent_q.offset);
          status_d     = ab_pkg::ST_OK;
          if (moving_q) begin
            state_d = S_FREE_OLD;
          end
        end else if (bump.status != ab_pkg::ST_OK) begin
          status_d = bump.status;
        end else begin
          // Bump placement at the end of the table
          wr_en          = 1'b1;
          wr_addr        = count_q[ab_pkg::IDX_W-1:0];
          wr_data.offset = bump.offset;
          wr_data.size   = size_q;
          wr_data.free   = 1'b0;
          count_d        = count_q + ab_pkg::CNT_W'(1);
          bucket_d       = bump.bucket;
          bump_d         = bump.bump;
          res_d          = ab_pkg::data_addr(bump.offset);
          status_d       = ab_pkg::ST_OK;
          if (moving_q) begin
            state_d = S_FREE_OLD;
          end
        end
      end

      // Moved resize releases the old block last
      S_FREE_OLD: begin
        wr_en        = 1'b1;
        wr_addr      = old_idx_q;
        wr_data      = old_ent_q;
        wr_data.free = 1'b1;
        from_d       = addr_q;
        copy_d       = 1'b1;
        status_d     = ab_pkg::ST_OK;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_res_d    = res_q;
          out_from_d   = from_q;
          out_copy_d   = copy_q;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FIND;
      moving_q    <= 1'b0;
      count_q     <= '0;
      bucket_q    <= '0;
      bump_q      <= '0;
      issue_idx_q <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      moving_q    <= moving_d;
      count_q     <= count_d;
      bucket_q    <= bucket_d;
      bump_q      <= bump_d;
      issue_idx_q <= issue_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    pend_idx_q   <= pend_idx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    hit_ent_q    <= hit_ent_d;
    old_idx_q    <= old_idx_d;
    old_ent_q    <= old_ent_d;
    res_q        <= res_d;
    from_q       <= from_d;
    copy_q       <= copy_d;
    status_q     <= status_d;
    out_res_q    <= out_res_d;
    out_from_q   <= out_from_d;
    out_copy_q   <= out_copy_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_res_q;
  assign copy_from_o      = out_from_q;
  assign copy_needed_o    = out_copy_q;
  assign status_o         = out_status_q;

endmodule

@@ hdl/ab_checker.sv @@
`include "arena_block_allocator_assert.svh"

module ab_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [ab_pkg::KIND_W-1:0] kind_i,
  input logic [ab_pkg::SIZE_W-1:0] size_bytes_i,
  input logic [ab_pkg::ADDR_W-1:0] address_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [ab_pkg::ADDR_W-1:0] result_address_o,
  input logic [ab_pkg::ADDR_W-1:0] copy_from_o,
  input logic                      copy_needed_o,
  input logic [ab_pkg::STAT_W-1:0] status_o
);

  // Stalled result holds
  `AB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_address_o) && $stable(status_o), "stalled result changed")

  // One request in flight: a transfer closes the input side
  `AB_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "input open right after a transfer")

  // A copy request comes only with a good move
  `AB_ASSERT_SAME(a_copy_ok, out_valid_o && copy_needed_o, (status_o == ab_pkg::ST_OK) && (copy_from_o != '0) && (result_address_o != '0), "copy without a good move")

  // Failures return null and no copy
  `AB_ASSERT_SAME(a_fail_null, out_valid_o && (status_o != ab_pkg::ST_OK), (result_address_o == '0) && !copy_needed_o && (copy_from_o == '0), "failure carries an address")

endmodule

bind arena_block_allocator ab_checker u_ab_checker (.*);
